### hdl/tank_refuel_cycle_sequencer_top_macros.svh
// Assertion macros for the checker of the tank refuel sequencer.
// Both macros expect signals named clock and reset in the scope where they are used.
`ifndef TANK_REFUEL_CYCLE_SEQUENCER_TOP_MACROS_SVH
`define TANK_REFUEL_CYCLE_SEQUENCER_TOP_MACROS_SVH

// The condition holds in the same cycle as the trigger.
`define TRCS_ASSERT_SAME(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("%m: assertion failed");

// The condition holds in the cycle after the trigger.
`define TRCS_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("%m: assertion failed");

`endif

### hdl/trcs_pkg.sv
`timescale 1ns / 1ps

package trcs_pkg;

   localparam int CNT_W = 10;
   localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;

   typedef enum logic [2:0] {
      ST_COLD    = 3'd0,
      ST_WARM    = 3'd1,
      ST_EXTRACT = 3'd2,
      ST_VENT    = 3'd3,
      ST_WAIT    = 3'd4,
      ST_UNDEF   = 3'd5
   } state_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_HAS_VENTING   = 3'd0;
   localparam logic [2:0] CSR_EXTRACT_LOW   = 3'd1;
   localparam logic [2:0] CSR_COLD_TARGET   = 3'd2;
   localparam logic [2:0] CSR_WARM_TARGET   = 3'd3;
   localparam logic [2:0] CSR_COLD_QUOTA    = 3'd4;
   localparam logic [2:0] CSR_WARM_QUOTA    = 3'd5;
   localparam logic [2:0] CSR_VENT_TARGET   = 3'd6;
   localparam logic [2:0] CSR_START_STATE   = 3'd7;

   localparam logic        CMD_START = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [15:0] tank_pressure;
      logic [15:0] tank_temperature;
   } req_type;

   typedef struct packed {
      logic [2:0] state_code;
      logic       cold_valve;
      logic       warm_valve;
      logic       extraction_valve;
      logic       switched;
   } rsp_type;

   typedef struct packed {
      logic             has_venting;
      logic [15:0]      extraction_low_pressure;
      logic [15:0]      cold_target_pressure;
      logic [15:0]      warm_target_pressure;
      logic [CNT_W-1:0] cold_refuel_quota;
      logic [CNT_W-1:0] warm_refuel_quota;
      logic [15:0]      vent_target_temperature;
      logic [2:0]       start_state;
   } cfg_type;

   typedef struct packed {
      state_type        state;
      logic [CNT_W-1:0] cold_started;
      logic [CNT_W-1:0] warm_started;
      logic             switched;
   } step_type;

endpackage

### hdl/tank_refuel_cycle_sequencer_top.sv
`timescale 1ns / 1ps

// Tank refuel cycle sequencer.
// req_* carries a start or a pressure/temperature sample; each transfer
// produces exactly one result on rsp_*: the state after the item, the three
// valve outputs and a flag telling whether the item caused a state entry.
// csr_* writes one of eight configuration registers by index; csr_ready is
// always high, and writes are meant to be made while no item is in flight.
// The item is registered at the input, evaluated against the held state,
// and the result is registered at the output.
// Throughput is one item per cycle while rsp_ready is high; the input
// register and the result register form a two-stage pipeline, and the
// state update is combinational comparisons and a counter increment.
// When rsp_ready is low the result holds, the input register fills, and
// req_ready drops only once both stages are occupied.
// Reset is synchronous: both stages empty, the sequencer state becomes
// undefined, counters clear and the configuration registers take their
// default values.

module tank_refuel_cycle_sequencer_top
   import trcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type          cfg;
   step_type         step;

   logic             in_valid_ff;
   logic             in_valid_in;
   req_type          in_data_ff;
   logic             out_valid_ff;
   logic             out_valid_in;
   rsp_type          out_data_ff;
   state_type        state_ff;
   logic [CNT_W-1:0] cold_started_ff;
   logic [CNT_W-1:0] warm_started_ff;
   logic             advance;

   assign csr_ready = 1'b1;

   trcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   trcs_next u_next (
      .req          (in_data_ff),
      .cfg          (cfg),
      .cur_state    (state_ff),
      .cold_started (cold_started_ff),
      .warm_started (warm_started_ff),
      .step         (step)
   );

   // The held item moves on when the result register is free or being emptied.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         state_ff        <= ST_UNDEF;
         cold_started_ff <= '0;
         warm_started_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff        <= step.state;
            cold_started_ff <= step.cold_started;
            warm_started_ff <= step.warm_started;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_data_ff <= req_data;
      if (advance) begin
         out_data_ff.state_code       <= step.state;
         out_data_ff.cold_valve       <= (step.state == ST_COLD);
         out_data_ff.warm_valve       <= (step.state == ST_WARM);
         out_data_ff.extraction_valve <= (step.state == ST_EXTRACT);
         out_data_ff.switched         <= step.switched;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

### hdl/trcs_csr.sv
`timescale 1ns / 1ps

module trcs_csr
   import trcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HAS_VENTING: cfg_in.has_venting             = csr_data[0];
            CSR_EXTRACT_LOW: cfg_in.extraction_low_pressure = csr_data;
            CSR_COLD_TARGET: cfg_in.cold_target_pressure    = csr_data;
            CSR_WARM_TARGET: cfg_in.warm_target_pressure    = csr_data;
            CSR_COLD_QUOTA:  cfg_in.cold_refuel_quota       = csr_data[CNT_W-1:0];
            CSR_WARM_QUOTA:  cfg_in.warm_refuel_quota       = csr_data[CNT_W-1:0];
            CSR_VENT_TARGET: cfg_in.vent_target_temperature = csr_data;
            CSR_START_STATE: cfg_in.start_state             = csr_data[2:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.has_venting             <= 1'b0;
         cfg_ff.extraction_low_pressure <= 16'd500;
         cfg_ff.cold_target_pressure    <= 16'd7000;
         cfg_ff.warm_target_pressure    <= 16'd7000;
         cfg_ff.cold_refuel_quota       <= '0;
         cfg_ff.warm_refuel_quota       <= '0;
         cfg_ff.vent_target_temperature <= 16'd29315;
         cfg_ff.start_state             <= ST_EXTRACT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/trcs_next.sv
`timescale 1ns / 1ps

module trcs_next
   import trcs_pkg::*;
(
   input  req_type          req,
   input  cfg_type          cfg,
   input  state_type        cur_state,
   input  logic [CNT_W-1:0] cold_started,
   input  logic [CNT_W-1:0] warm_started,
   output step_type         step
);

   state_type        target;
   logic [CNT_W-1:0] cold_base;
   logic [CNT_W-1:0] warm_base;

   always_comb begin
      target    = ST_UNDEF;
      cold_base = cold_started;
      warm_base = warm_started;
      step.state = cur_state;

      if (req.cmd == CMD_START) begin
         cold_base  = '0;
         warm_base  = '0;
         step.state = ST_UNDEF;
         if (cfg.start_state <= 3'(ST_WAIT)) begin
            target = state_type'(cfg.start_state);
         end
      end else begin
         case (cur_state)
            ST_COLD: begin
               if (req.tank_pressure > cfg.cold_target_pressure) begin
                  if (cfg.has_venting && cold_started == cfg.cold_refuel_quota) begin
                     target = ST_VENT;
                  end else begin
                     target = ST_EXTRACT;
                  end
               end
            end
            ST_WARM: begin
               if (req.tank_pressure > cfg.warm_target_pressure) target = ST_EXTRACT;
            end
            ST_EXTRACT: begin
               if (req.tank_pressure < cfg.extraction_low_pressure) begin
                  if (cold_started < cfg.cold_refuel_quota) begin
                     target = ST_COLD;
                  end else if (warm_started < cfg.warm_refuel_quota) begin
                     target = ST_WARM;
                  end else begin
                     target = ST_WAIT;
                  end
               end
            end
            ST_VENT: begin
               if (req.tank_temperature > cfg.vent_target_temperature) target = ST_EXTRACT;
            end
            default: target = ST_UNDEF;
         endcase
      end

      step.cold_started = cold_base;
      step.warm_started = warm_base;
      step.switched     = (target != ST_UNDEF);
      if (target != ST_UNDEF) begin
         step.state = target;
         // Refuel counters saturate at their top value.
         if (target == ST_COLD && cold_base != CNT_MAX) step.cold_started = cold_base + 1'b1;
         if (target == ST_WARM && warm_base != CNT_MAX) step.warm_started = warm_base + 1'b1;
      end
   end

endmodule

### hdl/trcs_checker.sv
`timescale 1ns / 1ps
`include "tank_refuel_cycle_sequencer_top_macros.svh"

module trcs_checker
   import trcs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic valves_ok;
   logic undef_rsp;

   assign valves_ok = (rsp_data.cold_valve == (rsp_data.state_code == ST_COLD)) &&
                      (rsp_data.warm_valve == (rsp_data.state_code == ST_WARM)) &&
                      (rsp_data.extraction_valve == (rsp_data.state_code == ST_EXTRACT));
   assign undef_rsp = rsp_valid && (rsp_data.state_code == ST_UNDEF);

   // A stalled result keeps its value until the transfer completes.
   `TRCS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Valves follow the reported state.
   `TRCS_ASSERT_SAME(a_valves, rsp_valid, valves_ok)

   // An item that leaves the state undefined never reports a state entry.
   `TRCS_ASSERT_SAME(a_undef_no_switch, undef_rsp, !rsp_data.switched)

   // A result is on offer once an input transfer has passed the input register and the result register.
   `TRCS_ASSERT_NEXT(a_result_follows, req_valid && req_ready, ##1 rsp_valid)

endmodule

bind tank_refuel_cycle_sequencer_top trcs_checker u_checker (.*);
